// ----- design/bqd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bqd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int NUM_CHANNELS = 2;
  localparam int NUM_LANES    = 2;
  localparam int COEF_WIDTH   = 18;
  localparam int FRAC_BITS    = 16;
  localparam int PROD_W       = COEF_WIDTH + SAMPLE_W;
  localparam int ACC_W        = PROD_W + 3;
  localparam int CFG_IDX_W    = 3;

  typedef logic signed [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_val_t;

  localparam sample_t SAMPLE_MAX = sample_t'(32767);
  localparam sample_t SAMPLE_MIN = sample_t'(-32768);

  localparam coef_val_t B0_RESET = coef_val_t'(18552);
  localparam coef_val_t B1_RESET = coef_val_t'(37104);
  localparam coef_val_t B2_RESET = coef_val_t'(18552);
  localparam coef_val_t A1_RESET = coef_val_t'(-7864);
  localparam coef_val_t A2_RESET = coef_val_t'(17520);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd5;

  typedef struct packed {
    coef_val_t b0;
    coef_val_t b1;
    coef_val_t b2;
    coef_val_t a1;
    coef_val_t a2;
  } coef_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic out_load;
    logic s3_valid;
  } ctl_t;

endpackage

`default_nettype wire

// ----- design/bqd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bqd_in_if import bqd_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample_left;
  sample_t sample_right;
  logic    frame_end;

  modport source (output valid, output sample_left, output sample_right,
                  output frame_end, input ready);
  modport sink (input valid, input sample_left, input sample_right,
                input frame_end, output ready);
endinterface

interface bqd_out_if import bqd_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t filtered_left;
  sample_t filtered_right;
  logic    frame_end_out;

  modport source (output valid, output filtered_left, output filtered_right,
                  output frame_end_out, input ready);
  modport sink (input valid, input filtered_left, input filtered_right,
                input frame_end_out, output ready);
endinterface

`default_nettype wire

// ----- design/bqd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bqd_ctrl import bqd_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  wire  in_frame_end,
  input  wire  out_ready,
  output logic in_ready,
  output logic out_valid,
  output logic fe_s3,
  output ctl_t ctl
);

  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, out_v_nxt;
  logic fe1_r, fe2_r, fe3_r;
  logic out_ld, s3_ld, s2_ld, s1_ld;

  assign out_ld   = s3_v_r && (!out_v_r || out_ready);
  assign s3_ld    = s2_v_r && (!s3_v_r || out_ld);
  assign s2_ld    = s1_v_r && (!s2_v_r || s3_ld);
  assign in_ready = !s1_v_r || s2_ld;
  assign s1_ld    = in_valid && in_ready;

  assign ctl.s1_load  = s1_ld;
  assign ctl.s2_load  = s2_ld;
  assign ctl.s3_load  = s3_ld;
  assign ctl.out_load = out_ld;
  assign ctl.s3_valid = s3_v_r;

  assign out_valid = out_v_r;
  assign fe_s3     = fe3_r;

  always_comb begin
    s1_v_nxt  = s1_ld  ? 1'b1 : (s2_ld  ? 1'b0 : s1_v_r);
    s2_v_nxt  = s2_ld  ? 1'b1 : (s3_ld  ? 1'b0 : s2_v_r);
    s3_v_nxt  = s3_ld  ? 1'b1 : (out_ld ? 1'b0 : s3_v_r);
    out_v_nxt = out_ld ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      fe1_r <= in_frame_end;
    end
    if (s2_ld) begin
      fe2_r <= fe1_r;
    end
    if (s3_ld) begin
      fe3_r <= fe2_r;
    end
  end

  // hold every staged item until the next stage takes it
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_ld |=> s1_v_r)
    else $error("stage 1 item dropped");
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !s3_ld |=> s2_v_r)
    else $error("stage 2 item dropped");
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !out_ld |=> s3_v_r)
    else $error("stage 3 item dropped");

endmodule

`default_nettype wire

// ----- design/bqd_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bqd_lane import bqd_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  ctl_t    ctl,
  input  wire     en,
  input  wire     clr,
  input  coef_t   coef,
  input  sample_t x_in,
  output sample_t y_out
);

  coef_val_t b0, b1, b2, a1, a2;

  sample_t xh1_r, xh2_r, yh1_r, yh2_r;

  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [ACC_W-1:0]  ff_r, ff_nxt;
  logic signed [ACC_W-1:0]  part_r, part_nxt;
  sample_t                  xs1_r, xs2_r, xs3_r;

  sample_t                  y2_sel;
  logic signed [PROD_W-1:0] a2_prod, a1_prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-FRAC_BITS-SAMPLE_W:0] acc_hi;
  sample_t                  y_sat;

  assign b0 = coef.b0;
  assign b1 = coef.b1;
  assign b2 = coef.b2;
  assign a1 = coef.a1;
  assign a2 = coef.a2;

  assign p0_nxt = b0 * x_in;
  assign p1_nxt = b1 * xh1_r;
  assign p2_nxt = b2 * xh2_r;
  assign ff_nxt = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r);

  // previous item still in stage 3: its output not yet in history
  assign y2_sel   = ctl.s3_valid ? yh1_r : yh2_r;
  assign a2_prod  = a2 * y2_sel;
  assign part_nxt = ff_r - ACC_W'(a2_prod);

  assign a1_prod = a1 * yh1_r;
  assign acc     = part_r - ACC_W'(a1_prod);
  assign acc_hi  = acc[ACC_W-1:FRAC_BITS+SAMPLE_W-1];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      y_sat = acc[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
    end else if (acc[ACC_W-1]) begin
      y_sat = SAMPLE_MIN;
    end else begin
      y_sat = SAMPLE_MAX;
    end
  end

  assign y_out = en ? y_sat : xs3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xh1_r <= '0;
      xh2_r <= '0;
      yh1_r <= '0;
      yh2_r <= '0;
    end else if (clr) begin
      xh1_r <= '0;
      xh2_r <= '0;
      yh1_r <= '0;
      yh2_r <= '0;
    end else begin
      if (ctl.s1_load && en) begin
        xh2_r <= xh1_r;
        xh1_r <= x_in;
      end
      if (ctl.out_load && en) begin
        yh2_r <= yh1_r;
        yh1_r <= y_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      xs1_r <= x_in;
    end
    if (ctl.s2_load) begin
      ff_r  <= ff_nxt;
      xs2_r <= xs1_r;
    end
    if (ctl.s3_load) begin
      part_r <= part_nxt;
      xs3_r  <= xs2_r;
    end
  end

  a_hist_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en && !clr |=> $stable({xh1_r, xh2_r, yh1_r, yh2_r}))
    else $error("history changed while bypassed");
  a_hist_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (xh1_r == '0) && (xh2_r == '0) && (yh1_r == '0) && (yh2_r == '0))
    else $error("history not cleared");

endmodule

`default_nettype wire

// ----- design/bqd_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bqd_merge import bqd_pkg::*; (
  input  wire                      clk,
  input  ctl_t                     ctl,
  input  sample_t [NUM_LANES-1:0]  lane_y,
  input  wire                      fe_in,
  output sample_t                  left_out,
  output sample_t                  right_out,
  output logic                     fe_out
);

  sample_t [NUM_LANES-1:0] y_r;
  logic                    fe_r;

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      y_r  <= lane_y;
      fe_r <= fe_in;
    end
  end

  assign left_out  = y_r[0];
  assign right_out = y_r[1];
  assign fe_out    = fe_r;

endmodule

`default_nettype wire

// ----- design/stereo_biquad_lowpass_q16_unit.sv -----
// A sample pair taken in moves through the stage 1, 2 and 3 registers to the out_ch output register.
// Throughput: one stereo pair per cycle while out_ch.ready does not stall the pipeline; three staged
//   steps per lane, with the a1*y1 multiply and saturation closing the feedback loop in the last step.
// Reset (synchronous, active low): filter enabled, coefficients at their
//   defaults, sample history cleared, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module stereo_biquad_lowpass_q16_unit import bqd_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  bqd_in_if.sink                 in_ch,
  bqd_out_if.source              out_ch,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [COEF_WIDTH-1:0]   cfg_wdata
);

  logic                    en_r;
  coef_t                   coef_r;
  logic                    clr;
  ctl_t                    ctl;
  logic                    fe_s3;
  logic                    in_rdy;
  logic                    out_vld;
  sample_t [NUM_LANES-1:0] lane_x;
  sample_t [NUM_LANES-1:0] lane_y;

  assign clr = cfg_we && (cfg_index == REG_ENABLE) && !cfg_wdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 1'b1;
      coef_r.b0 <= B0_RESET;
      coef_r.b1 <= B1_RESET;
      coef_r.b2 <= B2_RESET;
      coef_r.a1 <= A1_RESET;
      coef_r.a2 <= A2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: en_r      <= cfg_wdata[0];
        REG_B0:     coef_r.b0 <= cfg_wdata;
        REG_B1:     coef_r.b1 <= cfg_wdata;
        REG_B2:     coef_r.b2 <= cfg_wdata;
        REG_A1:     coef_r.a1 <= cfg_wdata;
        REG_A2:     coef_r.a2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bqd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_frame_end (in_ch.frame_end),
    .out_ready    (out_ch.ready),
    .in_ready     (in_rdy),
    .out_valid    (out_vld),
    .fe_s3        (fe_s3),
    .ctl          (ctl)
  );

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld;

  assign lane_x[0] = in_ch.sample_left;
  assign lane_x[1] = in_ch.sample_right;

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    bqd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .en    (en_r && (c < NUM_CHANNELS)),
      .clr   (clr),
      .coef  (coef_r),
      .x_in  (lane_x[c]),
      .y_out (lane_y[c])
    );
  end

  bqd_merge u_merge (
    .clk       (clk),
    .ctl       (ctl),
    .lane_y    (lane_y),
    .fe_in     (fe_s3),
    .left_out  (out_ch.filtered_left),
    .right_out (out_ch.filtered_right),
    .fe_out    (out_ch.frame_end_out)
  );

endmodule

`default_nettype wire
